// File: design/pfv_pkg.sv
package pfv_pkg;

    function automatic int maxi(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // fraction bits of the Q formats for angle, steps, velocity and scale
    localparam int FRAC_BITS  = 16;

    localparam int ANG_W      = 32;
    localparam int EST_W      = 48;
    localparam int DRV_W      = 16;
    localparam int VEL_W      = 32;

    localparam int SPD_W      = 24;
    localparam int KP_W       = 16;
    localparam int KP_FRAC    = 8;
    localparam int VMX_W      = 15;
    localparam int DB_W       = 24;
    localparam int TICK_W     = 16;
    localparam int TICK_FRAC  = 16;
    localparam int VSC_W      = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VMX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VSC  = 3'd5;

    localparam logic [SPD_W-1:0]  CFG_SPD_RST  = 24'd1820444;
    localparam logic [KP_W-1:0]   CFG_KP_RST   = 16'd1536;
    localparam logic [VMX_W-1:0]  CFG_VMX_RST  = 15'd600;
    localparam logic [DB_W-1:0]   CFG_DB_RST   = 24'd32768;
    localparam logic [TICK_W-1:0] CFG_TICK_RST = 16'd655;
    localparam logic [VSC_W-1:0]  CFG_VSC_RST  = 24'd1073709;

    // datapath widths
    localparam int DIFF_W = ANG_W + 1;
    localparam int TM_W   = DIFF_W + SPD_W - FRAC_BITS + 1;
    localparam int T_W    = TM_W + 1;
    localparam int ERR_W  = maxi(T_W, EST_W) + 1;
    // error clamp: anything at or above 2^(EC_W-1) saturates for every nonzero gain
    localparam int EC_W   = VMX_W + KP_FRAC + FRAC_BITS + 1;
    localparam int VMAG_W = VMX_W + FRAC_BITS;
    localparam int MA_W   = maxi(maxi(DIFF_W, EC_W), VMAG_W);
    localparam int MB_W   = maxi(maxi(SPD_W, KP_W), maxi(TICK_W, VSC_W));
    localparam int P_W    = MA_W + MB_W;
    localparam int KV_W   = P_W - KP_FRAC;
    localparam int DLT_W  = VMAG_W + 1;
    localparam int S_W    = maxi(EST_W, DLT_W + 1) + 1;
    localparam int VX_W   = maxi(VMAG_W, VEL_W) + 1;

    typedef logic [1:0] t_msel;
    localparam t_msel MS_TGT  = 2'd0;
    localparam t_msel MS_KP   = 2'd1;
    localparam t_msel MS_TICK = 2'd2;
    localparam t_msel MS_VSC  = 2'd3;

    typedef struct packed {
        logic [SPD_W-1:0]  spd;
        logic [KP_W-1:0]   kp;
        logic [VMX_W-1:0]  vmax;
        logic [DB_W-1:0]   dband;
        logic [TICK_W-1:0] tick;
        logic [VSC_W-1:0]  vsc;
    } t_cfg;

    typedef struct packed {
        logic  load_in;
        logic  do_diff;
        logic  mul_en;
        t_msel msel;
        logic  ld_err;
        logic  ld_mag;
        logic  ld_vel;
        logic  ld_est;
        logic  ld_drv;
        logic  ld_out;
    } t_cmd;

    typedef struct packed {
        logic tick_valid;
    } t_sts;

endpackage

// File: design/pfv_in_if.sv
interface pfv_in_if;
    import pfv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] target_angle;
    logic                    angle_valid;

    modport source (output valid, output target_angle, output angle_valid, input ready);
    modport sink   (input valid, input target_angle, input angle_valid, output ready);
endinterface

// File: design/pfv_out_if.sv
interface pfv_out_if;
    import pfv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [DRV_W-1:0] drive_word;
    logic signed [VEL_W-1:0] velocity_steps;
    logic signed [EST_W-1:0] position_estimate;

    modport source (output valid, output drive_word, output velocity_steps,
                    output position_estimate, input ready);
    modport sink   (input valid, input drive_word, input velocity_steps,
                    input position_estimate, output ready);
endinterface

// File: design/pfv_cfg.sv
module pfv_cfg
    import pfv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spd   <= CFG_SPD_RST;
            r_cfg.kp    <= CFG_KP_RST;
            r_cfg.vmax  <= CFG_VMX_RST;
            r_cfg.dband <= CFG_DB_RST;
            r_cfg.tick  <= CFG_TICK_RST;
            r_cfg.vsc   <= CFG_VSC_RST;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_SPD:  r_cfg.spd   <= i_data[SPD_W-1:0];
                CFG_KP:   r_cfg.kp    <= i_data[KP_W-1:0];
                CFG_VMX:  r_cfg.vmax  <= i_data[VMX_W-1:0];
                CFG_DB:   r_cfg.dband <= i_data[DB_W-1:0];
                CFG_TICK: r_cfg.tick  <= i_data[TICK_W-1:0];
                CFG_VSC:  r_cfg.vsc   <= i_data[VSC_W-1:0];
                default:  ;  // unknown index: ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/pfv_ctrl.sv
module pfv_ctrl
    import pfv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIFF = 4'd1;
    localparam logic [3:0] ST_MT   = 4'd2;
    localparam logic [3:0] ST_ERR  = 4'd3;
    localparam logic [3:0] ST_MAG  = 4'd4;
    localparam logic [3:0] ST_MK   = 4'd5;
    localparam logic [3:0] ST_VEL  = 4'd6;
    localparam logic [3:0] ST_MTK  = 4'd7;
    localparam logic [3:0] ST_EST  = 4'd8;
    localparam logic [3:0] ST_DRV  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       can_load;

    assign can_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.do_diff = 1'b1;
                n_state = i_sts.tick_valid ? ST_MT : ST_OUT;
            end
            ST_MT: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_TGT;
                n_state      = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.ld_err = 1'b1;
                n_state      = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.ld_mag = 1'b1;
                n_state      = ST_MK;
            end
            ST_MK: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_KP;
                n_state      = ST_VEL;
            end
            ST_VEL: begin
                o_cmd.ld_vel = 1'b1;
                n_state      = ST_MTK;
            end
            ST_MTK: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_TICK;
                n_state      = ST_EST;
            end
            ST_EST: begin
                // estimate update and the drive-scale multiply share this cycle
                o_cmd.ld_est = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_VSC;
                n_state      = ST_DRV;
            end
            ST_DRV: begin
                o_cmd.ld_drv = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (can_load) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: design/pfv_dp.sv
module pfv_dp
    import pfv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic signed [ANG_W-1:0] i_target_angle,
    input  logic                    i_angle_valid,
    output logic signed [DRV_W-1:0] o_drive_word,
    output logic signed [VEL_W-1:0] o_velocity_steps,
    output logic signed [EST_W-1:0] o_position_estimate
);

    localparam logic [EC_W-1:0] EC_CLAMP = {1'b1, {(EC_W-1){1'b0}}};

    // item and persistent state
    logic signed [ANG_W-1:0] r_angle;
    logic                    r_valid;
    logic                    r_org_lat;
    logic signed [ANG_W-1:0] r_origin;
    logic signed [EST_W-1:0] r_est;

    // working registers
    logic [DIFF_W-1:0]       r_dmag;
    logic                    r_dneg;
    logic [P_W-1:0]          r_prod;
    logic signed [ERR_W-1:0] r_err;
    logic                    r_eneg;
    logic                    r_dead;
    logic [EC_W-1:0]         r_emc;
    logic [VMAG_W-1:0]       r_vmag;
    logic [DRV_W-1:0]        r_drive;

    // result registers
    logic signed [DRV_W-1:0] r_o_drive;
    logic signed [VEL_W-1:0] r_o_vel;
    logic signed [EST_W-1:0] r_o_est;

    // angle difference against origin (zero on the latching tick)
    logic signed [ANG_W-1:0]  org_eff;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        dmag;

    assign org_eff = r_org_lat ? r_origin : r_angle;
    assign diff    = {r_angle[ANG_W-1], r_angle} - {org_eff[ANG_W-1], org_eff};
    assign dmag    = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

    // shared multiplier
    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;

    always_comb begin
        case (i_cmd.msel)
            MS_TGT: begin
                mul_a = MA_W'(r_dmag);
                mul_b = MB_W'(i_cfg.spd);
            end
            MS_KP: begin
                mul_a = MA_W'(r_emc);
                mul_b = MB_W'(i_cfg.kp);
            end
            MS_TICK: begin
                mul_a = MA_W'(r_vmag);
                mul_b = MB_W'(i_cfg.tick);
            end
            default: begin
                mul_a = MA_W'(r_vmag);
                mul_b = MB_W'(i_cfg.vsc);
            end
        endcase
    end

    // target in steps, error against estimate
    logic [P_W-1:0]          tsum;
    logic [TM_W-1:0]         tmag;
    logic signed [T_W-1:0]   target;
    logic signed [ERR_W-1:0] err;

    assign tsum   = r_prod + (P_W'(1) << (FRAC_BITS - 1));
    assign tmag   = tsum[FRAC_BITS +: TM_W];
    assign target = r_dneg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    assign err    = $signed({{(ERR_W-T_W){target[T_W-1]}}, target})
                  - $signed({{(ERR_W-EST_W){r_est[EST_W-1]}}, r_est});

    // error magnitude
    logic [ERR_W-1:0] emag;

    assign emag = r_err[ERR_W-1] ? (~r_err + 1'b1) : r_err;

    // velocity magnitude, clamped
    logic [P_W-1:0]    vsum;
    logic [KV_W-1:0]   vfull;
    logic [VMAG_W-1:0] vmaxw;
    logic [VMAG_W-1:0] vmag;

    assign vsum  = r_prod + (P_W'(1) << (KP_FRAC - 1));
    assign vfull = vsum[P_W-1:KP_FRAC];
    assign vmaxw = {i_cfg.vmax, {FRAC_BITS{1'b0}}};
    assign vmag  = r_dead ? '0 : ((vfull > KV_W'(vmaxw)) ? vmaxw : vfull[VMAG_W-1:0]);

    // estimate step with saturation at the 48-bit limits
    logic [P_W-1:0]           dsum;
    logic [DLT_W-1:0]         dlt;
    logic signed [DLT_W:0]    dlt_s;
    logic signed [S_W-1:0]    esum;
    logic                     e_ovf;
    logic signed [EST_W-1:0]  est_new;

    assign dsum  = r_prod + (P_W'(1) << (TICK_FRAC - 1));
    assign dlt   = dsum[TICK_FRAC +: DLT_W];
    assign dlt_s = r_eneg ? -$signed({1'b0, dlt}) : $signed({1'b0, dlt});
    assign esum  = $signed({{(S_W-EST_W){r_est[EST_W-1]}}, r_est})
                 + $signed({{(S_W-DLT_W-1){dlt_s[DLT_W]}}, dlt_s});
    assign e_ovf = !((&esum[S_W-1:EST_W-1]) || !(|esum[S_W-1:EST_W-1]));

    always_comb begin
        if (e_ovf) begin
            est_new = esum[S_W-1] ? {1'b1, {(EST_W-1){1'b0}}} : {1'b0, {(EST_W-1){1'b1}}};
        end else begin
            est_new = esum[EST_W-1:0];
        end
    end

    // drive word magnitude, saturated to 32767
    logic [P_W-1:0]             wsum;
    logic [P_W-2*FRAC_BITS-1:0] whi;
    logic [DRV_W-2:0]           wmag;

    assign wsum = r_prod + (P_W'(1) << (2*FRAC_BITS - 1));
    assign whi  = wsum[P_W-1:2*FRAC_BITS];
    assign wmag = (whi > (P_W-2*FRAC_BITS)'({(DRV_W-1){1'b1}})) ? {(DRV_W-1){1'b1}}
                                                               : whi[DRV_W-2:0];

    // velocity output, saturated to 32 bits signed
    logic [VX_W-1:0]  vx;
    logic [VEL_W-1:0] vel_out;

    assign vx = VX_W'(r_vmag);

    always_comb begin
        if (!r_eneg && (vx > VX_W'({1'b0, {(VEL_W-1){1'b1}}}))) begin
            vel_out = {1'b0, {(VEL_W-1){1'b1}}};
        end else if (r_eneg && (vx > VX_W'({1'b1, {(VEL_W-1){1'b0}}}))) begin
            vel_out = {1'b1, {(VEL_W-1){1'b0}}};
        end else if (r_eneg) begin
            vel_out = ~vx[VEL_W-1:0] + 1'b1;
        end else begin
            vel_out = vx[VEL_W-1:0];
        end
    end

    // state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_lat <= 1'b0;
            r_origin  <= '0;
            r_est     <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_valid <= i_angle_valid;
            end
            if (i_cmd.do_diff && r_valid && !r_org_lat) begin
                r_org_lat <= 1'b1;
                r_origin  <= r_angle;
            end
            if (i_cmd.ld_est) begin
                r_est <= est_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_angle <= i_target_angle;
        end
        if (i_cmd.do_diff) begin
            r_dmag <= dmag;
            r_dneg <= diff[DIFF_W-1];
        end
        if (i_cmd.mul_en) begin
            r_prod <= P_W'(mul_a) * P_W'(mul_b);
        end
        if (i_cmd.ld_err) begin
            r_err <= err;
        end
        if (i_cmd.ld_mag) begin
            r_eneg <= r_err[ERR_W-1];
            r_dead <= emag < ERR_W'(i_cfg.dband);
            r_emc  <= (emag >= ERR_W'(EC_CLAMP)) ? EC_CLAMP : emag[EC_W-1:0];
        end
        if (i_cmd.ld_vel) begin
            r_vmag <= vmag;
        end
        if (i_cmd.ld_drv) begin
            r_drive <= r_eneg ? (~{1'b0, wmag} + 1'b1) : {1'b0, wmag};
        end
        if (i_cmd.ld_out) begin
            r_o_est <= r_est;
            if (r_valid) begin
                r_o_drive <= r_drive;
                r_o_vel   <= vel_out;
            end else begin
                r_o_drive <= '0;
                r_o_vel   <= '0;
            end
        end
    end

    assign o_sts.tick_valid   = r_valid;
    assign o_drive_word        = r_o_drive;
    assign o_velocity_steps    = r_o_vel;
    assign o_position_estimate = r_o_est;

endmodule

// File: design/position_follow_p_velocity.sv
// A valid tick's item steps from acceptance through diff, the four multiplies, error,
// clamp, estimate and drive updates to output; a tick without a valid angle goes from
// diff straight to output. One shared multiplier serves the four multiplies. No new item
// enters until the last is in the output register, which holds it while the next is taken.
// Reset (synchronous, active low): config registers to defaults, origin unlatched,
// estimate zero, no result pending.
module position_follow_p_velocity
    import pfv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // tick items in, results out
    pfv_in_if.sink                i_in,
    pfv_out_if.source             o_out
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // register file for gains, limits and scales
    pfv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // sequencer: accept, diff, target multiply, error, magnitude, gain multiply,
    // clamp, tick multiply, estimate update with scale multiply, drive round, output
    pfv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic, origin and estimate state, output payload register
    pfv_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_target_angle      (i_in.target_angle),
        .i_angle_valid       (i_in.angle_valid),
        .o_drive_word        (o_out.drive_word),
        .o_velocity_steps    (o_out.velocity_steps),
        .o_position_estimate (o_out.position_estimate)
    );

endmodule
